### rtl/ils_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg
// shared types and constants of the indexed list store
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = 7;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_SET    = 3'd2;
    localparam logic [2:0] MODE_GET    = 3'd3;
    localparam logic [2:0] MODE_REMOVE = 3'd4;
    localparam logic [2:0] MODE_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]           mode;
        logic [6:0]           position;
        logic [WORD_BITS-1:0] word_in;
    } req_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word_out;
        logic [1:0]           status;
        logic [CNT_W-1:0]     length;
        logic                 is_empty;
    } rsp_item_t;

    typedef struct packed {
        logic capture;
        logic init;
        logic wr_word_pos;
        logic wr_word_cnt;
        logic wr_rdata_idx;
        logic rd_pos;
        logic rd_idx_dec;
        logic rd_idx_inc;
        logic idx_dec;
        logic idx_inc;
        logic cap_result;
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clear;
        logic load_out;
    } ils_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       error;
        logic       idx_at_pos;
        logic       idx_last;
    } ils_stat_t;

endpackage
`default_nettype wire

### rtl/ils_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ils_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/ils_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ils_ctrl
// sequencer for the list operations and the handshakes of both channels
// ----------------------------------------------------------------------------
module ils_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    input  wire ils_pkg::ils_stat_t stat,
    output ils_pkg::ils_cmd_t      cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_EXEC     = 9'b000000010,
        S_GET_WAIT = 9'b000000100,
        S_INS_RD   = 9'b000001000,
        S_INS_WR   = 9'b000010000,
        S_REM_CAP  = 9'b000100000,
        S_REM_RD   = 9'b001000000,
        S_REM_WR   = 9'b010000000,
        S_FINISH   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.init   = 1'b1;
                state_next = S_FINISH;
                if (!stat.error)
                begin
                    case (stat.mode)
                        ils_pkg::MODE_APPEND:
                        begin
                            cmd.wr_word_cnt = 1'b1;
                            cmd.cnt_inc     = 1'b1;
                        end
                        ils_pkg::MODE_INSERT: state_next = S_INS_RD;
                        ils_pkg::MODE_SET:    cmd.wr_word_pos = 1'b1;
                        ils_pkg::MODE_GET:
                        begin
                            cmd.rd_pos = 1'b1;
                            state_next = S_GET_WAIT;
                        end
                        ils_pkg::MODE_REMOVE:
                        begin
                            cmd.rd_pos = 1'b1;
                            state_next = S_REM_CAP;
                        end
                        ils_pkg::MODE_CLEAR:  cmd.cnt_clear = 1'b1;
                        default:              state_next = S_FINISH;
                    endcase
                end
            end
            S_GET_WAIT:
            begin
                cmd.cap_result = 1'b1;
                state_next     = S_FINISH;
            end
            S_INS_RD:
            begin
                if (stat.idx_at_pos)
                begin
                    cmd.wr_word_pos = 1'b1;
                    cmd.cnt_inc     = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.rd_idx_dec = 1'b1;
                    state_next     = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_rdata_idx = 1'b1;
                cmd.idx_dec      = 1'b1;
                state_next       = S_INS_RD;
            end
            S_REM_CAP:
            begin
                cmd.cap_result = 1'b1;
                state_next     = S_REM_RD;
            end
            S_REM_RD:
            begin
                if (stat.idx_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.rd_idx_inc = 1'b1;
                    state_next     = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                cmd.wr_rdata_idx = 1'b1;
                cmd.idx_inc      = 1'b1;
                state_next       = S_REM_RD;
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

### rtl/ils_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ils_datapath
// item registers, element count, shift index, result registers and store
// ----------------------------------------------------------------------------
module ils_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ils_pkg::req_item_t req,
    output ils_pkg::rsp_item_t      rsp,
    input  wire ils_pkg::ils_cmd_t  cmd,
    output ils_pkg::ils_stat_t      stat
);

    localparam int AW = ils_pkg::ADDR_W;
    localparam int CW = ils_pkg::CNT_W;
    localparam int WB = ils_pkg::WORD_BITS;

    logic [2:0]    mode_reg;
    logic [6:0]    pos_reg;
    logic [WB-1:0] word_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    status_reg;
    logic [WB-1:0] result_reg;
    ils_pkg::rsp_item_t rsp_reg;

    logic          range_err;
    logic          full_err;
    logic [1:0]    status_code;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] idx_inc;
    logic [CW:0]   idx_inc_wide;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WB-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [WB-1:0] ram_rdata;

    always_comb
    begin
        range_err = 1'b0;
        full_err  = 1'b0;
        case (mode_reg)
            ils_pkg::MODE_APPEND: full_err = (count_reg >= ils_pkg::CAP_COUNT);
            ils_pkg::MODE_INSERT:
            begin
                range_err = (pos_reg > count_reg);
                full_err  = !range_err && (count_reg >= ils_pkg::CAP_COUNT);
            end
            ils_pkg::MODE_SET,
            ils_pkg::MODE_GET,
            ils_pkg::MODE_REMOVE: range_err = (pos_reg >= count_reg);
            default:
            begin
                range_err = 1'b0;
                full_err  = 1'b0;
            end
        endcase
        if (range_err)
        begin
            status_code = ils_pkg::ST_RANGE;
        end
        else if (full_err)
        begin
            status_code = ils_pkg::ST_FULL;
        end
        else
        begin
            status_code = ils_pkg::ST_OK;
        end
    end

    assign idx_dec      = idx_reg - CW'(1);
    assign idx_inc      = idx_reg + CW'(1);
    assign idx_inc_wide = {1'b0, idx_reg} + (CW+1)'(1);

    assign stat.mode       = mode_reg;
    assign stat.error      = range_err || full_err;
    assign stat.idx_at_pos = (idx_reg == pos_reg);
    assign stat.idx_last   = (idx_inc_wide >= {1'b0, count_reg});

    // store port selection
    always_comb
    begin
        ram_we    = cmd.wr_word_pos || cmd.wr_word_cnt || cmd.wr_rdata_idx;
        ram_wdata = cmd.wr_rdata_idx ? ram_rdata : word_reg;
        if (cmd.wr_word_pos)
        begin
            ram_waddr = pos_reg[AW-1:0];
        end
        else if (cmd.wr_word_cnt)
        begin
            ram_waddr = count_reg[AW-1:0];
        end
        else
        begin
            ram_waddr = idx_reg[AW-1:0];
        end
        if (cmd.rd_pos)
        begin
            ram_raddr = pos_reg[AW-1:0];
        end
        else if (cmd.rd_idx_dec)
        begin
            ram_raddr = idx_dec[AW-1:0];
        end
        else if (cmd.rd_idx_inc)
        begin
            ram_raddr = idx_inc[AW-1:0];
        end
        else
        begin
            ram_raddr = idx_reg[AW-1:0];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_clear)
        begin
            count_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.init)
        begin
            idx_next = (mode_reg == ils_pkg::MODE_INSERT) ? count_reg : pos_reg;
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_dec;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.capture)
        begin
            mode_reg <= req.mode;
            pos_reg  <= req.position;
            word_reg <= req.word_in;
        end
        if (cmd.init)
        begin
            status_reg <= status_code;
            result_reg <= '0;
        end
        else if (cmd.cap_result)
        begin
            result_reg <= ram_rdata;
        end
        if (cmd.load_out)
        begin
            rsp_reg.word_out <= result_reg;
            rsp_reg.status   <= status_reg;
            rsp_reg.length   <= count_reg;
            rsp_reg.is_empty <= (count_reg == '0);
        end
    end

    assign rsp = rsp_reg;

    ils_ram #(
        .WIDTH (WB),
        .DEPTH (ils_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

### rtl/indexed_list_store_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store_core
// ordered list of words with append, insert, set, get, remove and clear
//
// request beat (req_valid / req_stall) carries mode, position and word_in;
// response beat (rsp_valid / rsp_stall) carries word_out, status, length
// and is_empty, one response per request, in order.
// a request is taken only while the sequencer is idle; req_stall is high
// for the rest of the operation. the list lives in a single write, single
// read ram, so each shifted entry passes through a read state and a write state.
// append, set, clear, unused modes and errors go from exec to finish; get
// adds a wait state; insert and remove loop over the shifted entries, and
// remove first captures the word that it takes out.
// the response turns valid as the sequencer returns to idle, in the same
// cycle that the next request can be taken.
// the response sits in an output register; a stalled response holds and
// the next request is still taken, its result waiting until the register
// frees. reset empties the list at once; the store contents are left as is.
// ----------------------------------------------------------------------------
module indexed_list_store_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire ils_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output ils_pkg::rsp_item_t      rsp
);

    ils_pkg::ils_cmd_t  cmd;
    ils_pkg::ils_stat_t stat;

    ils_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ils_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
`default_nettype wire

### tb/list_store_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_store_checker
// watches both beat channels of indexed_list_store_core, keeps its own copy of
// the list, works out the response of every accepted request and compares
// each accepted response, field by field, with the oldest one still owed
// ----------------------------------------------------------------------------
module list_store_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               req_stall,
    input  wire ils_pkg::req_item_t req,
    input  wire logic               rsp_valid,
    input  wire logic               rsp_stall,
    input  wire ils_pkg::rsp_item_t rsp,
    output int                      fail_count,
    output int                      pending,
    output int                      checked,
    output int                      full_seen,
    output int                      range_seen,
    output logic [ils_pkg::CNT_W-1:0] list_len
);

    logic [ils_pkg::WORD_BITS-1:0] shadow_words [ils_pkg::CAPACITY];
    int unsigned                   shadow_len = 0;
    ils_pkg::rsp_item_t            owed_rsp [$];
    int                            errors = 0;
    int                            n_checked = 0;
    int                            n_full = 0;
    int                            n_range = 0;

    function automatic ils_pkg::rsp_item_t apply_list_op(input ils_pkg::req_item_t op);
        ils_pkg::rsp_item_t res;
        int unsigned        pos;
        int unsigned        i;
        res = '0;
        res.status = ils_pkg::ST_OK;
        pos = op.position;
        case (op.mode)
            ils_pkg::MODE_APPEND:
            begin
                if (shadow_len >= ils_pkg::CAPACITY)
                    res.status = ils_pkg::ST_FULL;
                else
                begin
                    shadow_words[shadow_len] = op.word_in;
                    shadow_len++;
                end
            end
            ils_pkg::MODE_INSERT:
            begin
                if (pos > shadow_len)
                    res.status = ils_pkg::ST_RANGE;
                else if (shadow_len >= ils_pkg::CAPACITY)
                    res.status = ils_pkg::ST_FULL;
                else
                begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[pos] = op.word_in;
                    shadow_len++;
                end
            end
            ils_pkg::MODE_SET:
            begin
                if (pos >= shadow_len)
                    res.status = ils_pkg::ST_RANGE;
                else
                    shadow_words[pos] = op.word_in;
            end
            ils_pkg::MODE_GET:
            begin
                if (pos >= shadow_len)
                    res.status = ils_pkg::ST_RANGE;
                else
                    res.word_out = shadow_words[pos];
            end
            ils_pkg::MODE_REMOVE:
            begin
                if (pos >= shadow_len)
                    res.status = ils_pkg::ST_RANGE;
                else
                begin
                    res.word_out = shadow_words[pos];
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_len--;
                end
            end
            ils_pkg::MODE_CLEAR:
                shadow_len = 0;
            default:
                ;
        endcase
        res.length = ils_pkg::CNT_W'(shadow_len);
        res.is_empty = (shadow_len == 0);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ils_pkg::rsp_item_t want;
        if (!rst_n)
        begin
            shadow_len = 0;
            owed_rsp.delete();
        end
        else
        begin
            // response first: a response never belongs to a request of the same edge
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_rsp.size() == 0)
                begin
                    $error("response beat with nothing owed: word_out %h status %0d length %0d",
                           rsp.word_out, rsp.status, rsp.length);
                    errors++;
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    n_checked++;
                    if (rsp.word_out !== want.word_out)
                    begin
                        $error("word_out: expected %h, actual %h", want.word_out, rsp.word_out);
                        errors++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.length !== want.length)
                    begin
                        $error("length: expected %0d, actual %0d", want.length, rsp.length);
                        errors++;
                    end
                    if (rsp.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, actual %0d",
                               want.is_empty, rsp.is_empty);
                        errors++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                want = apply_list_op(req);
                if (want.status == ils_pkg::ST_FULL)
                    n_full++;
                if (want.status == ils_pkg::ST_RANGE)
                    n_range++;
                owed_rsp.push_back(want);
            end
        end
        fail_count <= errors;
        pending    <= owed_rsp.size();
        checked    <= n_checked;
        full_seen  <= n_full;
        range_seen <= n_range;
        list_len   <= ils_pkg::CNT_W'(shadow_len);
    end

endmodule

### tb/tb_indexed_list_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_store_core
// drives request beats into indexed_list_store_core: a short directed run over
// empty-list errors, middle and tail shifts, unused modes and clear, then random
// phases that grow the list to full, churn it and drain it, with random gaps
// on both channels and one long response hold-off; list_store_checker does
// the prediction and comparison, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_indexed_list_store_core;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         DRAIN_CYCLES   = 150;
    localparam logic [2:0] MODE_SPARE_LO  = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

    typedef enum int {LEAN_GROW, LEAN_SHRINK, LEAN_MIX} lean_t;

    logic               clk;
    logic               rst_n;
    logic               req_valid = 1'b0;
    logic               req_stall;
    ils_pkg::req_item_t req = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    ils_pkg::rsp_item_t rsp;

    int                        fail_count;
    int                        pending;
    int                        checked;
    int                        full_seen;
    int                        range_seen;
    logic [ils_pkg::CNT_W-1:0] list_len;

    int sent = 0;
    int hold_asked = 0;
    int hold_served = 0;
    bit quiet_links = 1'b0;

    indexed_list_store_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    list_store_checker list_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .full_seen  (full_seen),
        .range_seen (range_seen),
        .list_len   (list_len)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [2:0] pick_mode(input lean_t lean);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 98)
            return ($urandom_range(0, 1) == 0) ? MODE_SPARE_LO : MODE_SPARE_HI;
        case (lean)
            LEAN_GROW:
            begin
                if (r < 45)
                    return ils_pkg::MODE_APPEND;
                if (r < 85)
                    return ils_pkg::MODE_INSERT;
                if (r < 92)
                    return ils_pkg::MODE_GET;
                if (r < 96)
                    return ils_pkg::MODE_SET;
                return ils_pkg::MODE_REMOVE;
            end
            LEAN_SHRINK:
            begin
                if (r < 55)
                    return ils_pkg::MODE_REMOVE;
                if (r < 70)
                    return ils_pkg::MODE_GET;
                if (r < 80)
                    return ils_pkg::MODE_SET;
                if (r < 88)
                    return ils_pkg::MODE_APPEND;
                if (r < 96)
                    return ils_pkg::MODE_INSERT;
                return ils_pkg::MODE_CLEAR;
            end
            default:
            begin
                if (r < 18)
                    return ils_pkg::MODE_APPEND;
                if (r < 36)
                    return ils_pkg::MODE_INSERT;
                if (r < 52)
                    return ils_pkg::MODE_SET;
                if (r < 73)
                    return ils_pkg::MODE_GET;
                if (r < 95)
                    return ils_pkg::MODE_REMOVE;
                return ils_pkg::MODE_CLEAR;
            end
        endcase
    endfunction

    function automatic logic [6:0] pick_position(input int len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 7'($urandom_range(0, len));
        if (r < 94)
            return 7'($urandom_range((len > 0) ? len - 1 : 0, len + 1));
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [ils_pkg::WORD_BITS-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return ils_pkg::WORD_BITS'($urandom());
    endfunction

    task automatic push_op(input logic [2:0] mode, input logic [6:0] position,
                           input logic [ils_pkg::WORD_BITS-1:0] word);
        ils_pkg::req_item_t item;
        int                 gap;
        item.mode     = mode;
        item.position = position;
        item.word_in  = word;
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent++;
        gap = pick_gap(quiet_links);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_phase(input lean_t lean, input int count);
        int k;
        for (k = 0; k < count; k++)
            push_op(pick_mode(lean), pick_position(int'(list_len)), pick_word());
    endtask

    // response side: random stalls, plus the long hold-off when asked
    initial
    begin
        int g;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_asked != hold_served)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end
            else
            begin
                g = pick_gap(quiet_links);
                if (g > 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (g) @(posedge clk);
                end
                rsp_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no beat for %0d cycles, %0d responses still owed", idle, pending);
        $display("indexed_list_store_core: mismatch");
        $finish;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);

        // empty list errors
        push_op(ils_pkg::MODE_GET, 7'd0, '1);
        push_op(ils_pkg::MODE_REMOVE, 7'd0, '0);
        push_op(ils_pkg::MODE_SET, 7'd0, '1);
        push_op(ils_pkg::MODE_INSERT, 7'd1, '1);
        // build a short list, insert at the end and in the middle
        push_op(ils_pkg::MODE_INSERT, 7'd0, '1);
        push_op(ils_pkg::MODE_APPEND, 7'd0, '0);
        push_op(ils_pkg::MODE_APPEND, 7'd127, 32'hA5A5_A5A5);
        push_op(ils_pkg::MODE_INSERT, 7'd3, 32'h5A5A_5A5A);
        push_op(ils_pkg::MODE_INSERT, 7'd1, 32'h1234_5678);
        push_op(ils_pkg::MODE_SET, 7'd4, 32'h8000_0001);
        push_op(ils_pkg::MODE_GET, 7'd0, '0);
        push_op(ils_pkg::MODE_GET, 7'd4, '0);
        push_op(ils_pkg::MODE_GET, 7'd5, '0);
        push_op(ils_pkg::MODE_GET, 7'd127, '0);
        push_op(ils_pkg::MODE_SET, 7'd5, '1);
        // remove from the middle and the tail, then past the end
        push_op(ils_pkg::MODE_REMOVE, 7'd1, '0);
        push_op(ils_pkg::MODE_REMOVE, 7'd3, '0);
        push_op(ils_pkg::MODE_REMOVE, 7'd3, '0);
        push_op(MODE_SPARE_LO, 7'd0, '1);
        push_op(MODE_SPARE_HI, 7'd127, '1);
        push_op(ils_pkg::MODE_GET, 7'd2, '0);
        push_op(ils_pkg::MODE_CLEAR, 7'd64, '1);
        push_op(ils_pkg::MODE_GET, 7'd0, '0);
        push_op(ils_pkg::MODE_CLEAR, 7'd0, '0);

        // random phases: fill to capacity, churn under a long hold-off, drain
        quiet_links = ($urandom_range(0, 3) == 0);
        run_phase(LEAN_GROW, 120);
        quiet_links = 1'b1;
        hold_asked++;
        run_phase(LEAN_MIX, 150);
        quiet_links = ($urandom_range(0, 3) == 0);
        run_phase(LEAN_SHRINK, 100);
        quiet_links = ($urandom_range(0, 3) == 0);
        run_phase(LEAN_GROW, 120);
        quiet_links = ($urandom_range(0, 3) == 0);
        run_phase(LEAN_MIX, 150);
        quiet_links = ($urandom_range(0, 3) == 0);
        run_phase(LEAN_SHRINK, 80);
        quiet_links = 1'b0;
        run_phase(LEAN_GROW, 80);

        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests, compared %0d responses", sent, checked);
        $display("responses with a full list: %0d, with a position out of range: %0d",
                 full_seen, range_seen);
        if (fail_count == 0 && pending == 0)
            $display("indexed_list_store_core: match");
        else
            $display("indexed_list_store_core: mismatch");
        $finish;
    end

endmodule

### filelist.f
rtl/ils_pkg.sv
rtl/ils_ram.sv
rtl/ils_ctrl.sv
rtl/ils_datapath.sv
rtl/indexed_list_store_core.sv
tb/list_store_checker.sv
tb/tb_indexed_list_store_core.sv
